// ===== rtl/mlfr_pkg.sv =====
// Shared types and constants for the marker/length frame receiver.
package mlfr_pkg;

  localparam int unsigned ACK_FRAME_BYTES    = 3;
  localparam int unsigned MSG_HEADER_BYTES   = 4;
  localparam int unsigned MSG_OVERHEAD_BYTES = 5;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_MSG_MARKER = 2'd0,
    CFG_ACK_MARKER = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_CHECK_EN   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_MSG  = 2'd1,
    FT_ACK  = 2'd2
  } frame_type_t;

  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_MSG_OK   = 3'd1,
    ST_CHK_ERR  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_ACK_DONE = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  message_marker;
    logic [7:0]  ack_marker;
    logic [15:0] receive_timeout;
    logic        check_enable;
  } cfg_t;

  typedef struct packed {
    logic        byte_valid;
    frame_type_t frame_type;
    logic [8:0]  position;
    logic [7:0]  byte_out;
    logic        frame_end;
    status_t     status;
    logic [7:0]  target_addr;
    logic [7:0]  source_addr;
    logic [7:0]  payload_length;
  } result_t;

endpackage

// ===== rtl/mlfr_cfg.sv =====
// Configuration register file: markers, receive timeout, checksum enable.
module mlfr_cfg
  import mlfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cfg_reg_t   wr_index,
  input  logic [7:0] wr_data_lo,
  input  logic [15:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.message_marker  <= 8'd0;
      cfg_r.ack_marker      <= 8'd0;
      cfg_r.receive_timeout <= TIMEOUT_RESET;
      cfg_r.check_enable    <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MSG_MARKER: cfg_r.message_marker  <= wr_data_lo;
        CFG_ACK_MARKER: cfg_r.ack_marker      <= wr_data_lo;
        CFG_TIMEOUT:    cfg_r.receive_timeout <= wr_data;
        CFG_CHECK_EN:   cfg_r.check_enable    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mlfr_core.sv =====
// Frame tracking state and the per-transaction result logic.
module mlfr_core
  import mlfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic        in_frame_r, in_frame_nxt;
  frame_type_t kind_r, kind_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic        open_msg, open_ack;
  logic [15:0] idle_inc;
  frame_type_t ft;
  logic [8:0]  pos;
  logic [7:0]  xor_cur;
  logic        fend;

  always_comb begin
    in_frame_nxt = in_frame_r;
    kind_nxt     = kind_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    tgt_nxt      = tgt_r;
    src_nxt      = src_r;
    xor_nxt      = xor_r;
    idle_nxt     = idle_r;
    res          = '0;
    open_msg     = (rx_byte == cfg.message_marker);
    open_ack     = (rx_byte == cfg.ack_marker);
    idle_inc     = (idle_r != IDLE_MAX) ? idle_r + 16'd1 : idle_r;
    ft           = in_frame_r ? kind_r : (open_msg ? FT_MSG : FT_ACK);
    pos          = in_frame_r ? count_r : 9'd0;
    xor_cur      = in_frame_r ? xor_r : 8'd0;
    fend         = 1'b0;

    if (kind) begin
      idle_nxt = idle_inc;
      if (in_frame_r && (idle_inc >= cfg.receive_timeout)) begin
        res.status         = ST_TIMEOUT;
        res.frame_type     = kind_r;
        res.target_addr    = tgt_r;
        res.source_addr    = src_r;
        res.payload_length = len_r;
        in_frame_nxt       = 1'b0;
        kind_nxt           = FT_NONE;
        count_nxt          = 9'd0;
        xor_nxt            = 8'd0;
      end
    end else begin
      idle_nxt = 16'd0;
      if (!in_frame_r && !open_msg && !open_ack) begin
        res.status = ST_IGNORED;
      end else begin
        // a new frame clears the held header fields
        if (!in_frame_r) begin
          tgt_nxt = 8'd0;
          src_nxt = 8'd0;
          len_nxt = 8'd0;
        end
        res.status = ST_PROGRESS;
        if (ft == FT_ACK) begin
          if (pos >= 9'(ACK_FRAME_BYTES - 1)) begin
            fend       = 1'b1;
            res.status = ST_ACK_DONE;
          end
        end else begin
          if (pos == 9'd1) tgt_nxt = rx_byte;
          if (pos == 9'd2) src_nxt = rx_byte;
          if (pos == 9'd3) len_nxt = rx_byte;
          // last byte sits at length + overhead - 1
          if ((pos >= 9'(MSG_HEADER_BYTES)) &&
              (pos == {1'b0, len_nxt} + 9'(MSG_OVERHEAD_BYTES - 1))) begin
            fend = 1'b1;
            priority if (len_nxt == 8'd0)                     res.status = ST_EMPTY;
            else if (cfg.check_enable && (xor_cur != rx_byte)) res.status = ST_CHK_ERR;
            else                                               res.status = ST_MSG_OK;
          end
        end
        res.byte_valid     = 1'b1;
        res.frame_type     = ft;
        res.position       = pos;
        res.byte_out       = rx_byte;
        res.frame_end      = fend;
        res.target_addr    = tgt_nxt;
        res.source_addr    = src_nxt;
        res.payload_length = len_nxt;
        if (fend) begin
          in_frame_nxt = 1'b0;
          kind_nxt     = FT_NONE;
          count_nxt    = 9'd0;
          xor_nxt      = 8'd0;
        end else begin
          in_frame_nxt = 1'b1;
          kind_nxt     = ft;
          count_nxt    = pos + 9'd1;
          xor_nxt      = xor_cur ^ rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      kind_r     <= FT_NONE;
      count_r    <= 9'd0;
      len_r      <= 8'd0;
      tgt_r      <= 8'd0;
      src_r      <= 8'd0;
      xor_r      <= 8'd0;
      idle_r     <= 16'd0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      kind_r     <= kind_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      tgt_r      <= tgt_nxt;
      src_r      <= src_nxt;
      xor_r      <= xor_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

// ===== rtl/marker_length_frame_receiver.sv =====
// Top level of the marker/length frame receiver.
//
// Each input transaction is a received byte (in_kind 0) or a time tick
// (in_kind 1) and produces exactly one result transaction. Outside a frame,
// bytes equal to message_marker open a message frame (marker, target, source,
// length, payload, XOR checksum), bytes equal to ack_marker open a three-byte
// acknowledge frame, and all others are reported as ignored. Every framed
// byte is echoed with its position and the header fields held so far; the
// last byte carries the frame status. Ticks count idle time since the last
// byte, and an open frame is dropped with a timeout status once that count
// reaches receive_timeout. Timing: two register stages, an input register
// and a result register; an accepted transaction waits in the input
// register until the result register is free, and its result is then
// registered there; one transaction per cycle is sustained as long as
// out_stall stays low. The frame state updates as an item moves from
// the input register to the result register. Configuration writes are
// always ready and take effect on the next cycle; write only while no
// transaction is in flight.
module marker_length_frame_receiver
  import mlfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_valid,
  output logic [1:0]  out_frame_type,
  output logic [8:0]  out_position,
  output logic [7:0]  out_byte_out,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic [7:0]  out_target_addr,
  output logic [7:0]  out_source_addr,
  output logic [7:0]  out_payload_length,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  result_t res;

  logic       s1_valid_r;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;

  logic out_free;
  logic step;

  // result register can take a new item when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign cfg_ready = 1'b1;

  mlfr_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid),
    .wr_index   (cfg_reg_t'(cfg_index)),
    .wr_data_lo (cfg_data[7:0]),
    .wr_data    (cfg_data),
    .cfg        (cfg)
  );

  mlfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .kind    (s1_kind_r),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_valid     = out_r.byte_valid;
  assign out_frame_type     = out_r.frame_type;
  assign out_position       = out_r.position;
  assign out_byte_out       = out_r.byte_out;
  assign out_frame_end      = out_r.frame_end;
  assign out_status         = out_r.status;
  assign out_target_addr    = out_r.target_addr;
  assign out_source_addr    = out_r.source_addr;
  assign out_payload_length = out_r.payload_length;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the marker/length frame receiver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfr_pkg::*;

  // Item kinds on the input channel.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Two register stages in the DUT; a little margin after the last result.
  localparam int DRAIN_CYCLES  = 4;
  // Non-ignored items per configuration setting in the random sweep.
  localparam int TRAFFIC_ITEMS = 80;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        in_kind    = KIND_BYTE;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        out_byte_valid;
  logic [1:0]  out_frame_type;
  logic [8:0]  out_position;
  logic [7:0]  out_byte_out;
  logic        out_frame_end;
  logic [2:0]  out_status;
  logic [7:0]  out_target_addr;
  logic [7:0]  out_source_addr;
  logic [7:0]  out_payload_length;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index  = CFG_MSG_MARKER;
  logic [15:0] cfg_data   = '0;

  marker_length_frame_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_valid     (out_byte_valid),
    .out_frame_type     (out_frame_type),
    .out_position       (out_position),
    .out_byte_out       (out_byte_out),
    .out_frame_end      (out_frame_end),
    .out_status         (out_status),
    .out_target_addr    (out_target_addr),
    .out_source_addr    (out_source_addr),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial forever #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the registers and of the frame tracker
  // ---------------------------------------------------------------------------
  logic [7:0]  msg_marker;
  logic [7:0]  ack_marker;
  logic [15:0] rx_timeout;
  logic        chk_en;

  logic        frame_open;
  frame_type_t frame_kind;
  logic [8:0]  frame_bytes;   // bytes already taken into the open frame
  logic [7:0]  hold_len;
  logic [7:0]  hold_tgt;
  logic [7:0]  hold_src;
  logic [7:0]  frame_xor;     // XOR of the bytes taken so far
  logic [15:0] ticks_idle;    // ticks since the last byte, saturating

  // Expected results, oldest first.
  result_t pending_results[$];

  // Stimulus knobs.
  int send_idle_pct = 15;
  int recv_idle_pct = 49;
  bit tick_jitter   = 1'b0;   // short tick bursts between framed bytes

  // Bookkeeping.
  int fail_count   = 0;
  int items_useful = 0;       // accepted items that the block did not ignore
  int n_bytes      = 0;
  int n_ticks      = 0;
  int n_checked    = 0;
  int status_tally[8];

  task automatic reset_model;
    msg_marker  = 8'd0;
    ack_marker  = 8'd0;
    rx_timeout  = TIMEOUT_RESET;
    chk_en      = 1'b1;
    frame_open  = 1'b0;
    frame_kind  = FT_NONE;
    frame_bytes = '0;
    hold_len    = '0;
    hold_tgt    = '0;
    hold_src    = '0;
    frame_xor   = '0;
    ticks_idle  = '0;
  endtask

  // Advance the frame tracker by one item and return the result it causes.
  function automatic result_t frame_step(input logic kind, input logic [7:0] b);
    result_t    r;
    logic [8:0] pos;
    logic       fin;
    status_t    st;
    r = '0;
    if (kind == KIND_TICK) begin
      if (ticks_idle != IDLE_MAX) ticks_idle = ticks_idle + 16'd1;
      if (frame_open && ticks_idle >= rx_timeout) begin
        // stale frame: report what was held, then drop it
        r.frame_type     = frame_kind;
        r.status         = ST_TIMEOUT;
        r.target_addr    = hold_tgt;
        r.source_addr    = hold_src;
        r.payload_length = hold_len;
        frame_open  = 1'b0;
        frame_kind  = FT_NONE;
        frame_bytes = '0;
        frame_xor   = '0;
      end
      return r;
    end

    ticks_idle = '0;
    if (!frame_open) begin
      // message marker wins when both markers are equal
      if (b == msg_marker) frame_kind = FT_MSG;
      else if (b == ack_marker) frame_kind = FT_ACK;
      else begin
        r.status = ST_IGNORED;
        return r;
      end
      frame_open  = 1'b1;
      frame_bytes = '0;
      frame_xor   = '0;
      hold_len    = '0;
      hold_tgt    = '0;
      hold_src    = '0;
    end

    pos = frame_bytes;
    fin = 1'b0;
    st  = ST_PROGRESS;
    if (frame_kind == FT_ACK) begin
      if (pos + 1 >= ACK_FRAME_BYTES) begin
        fin = 1'b1;
        st  = ST_ACK_DONE;
      end
    end else begin
      case (pos)
        9'd1: hold_tgt = b;
        9'd2: hold_src = b;
        9'd3: hold_len = b;
        default: ;
      endcase
      if (pos >= MSG_HEADER_BYTES && pos + 1 == hold_len + MSG_OVERHEAD_BYTES) begin
        fin = 1'b1;
        if (hold_len == 8'd0) st = ST_EMPTY;
        else if (chk_en && frame_xor != b) st = ST_CHK_ERR;
        else st = ST_MSG_OK;
      end
    end

    r.byte_valid     = 1'b1;
    r.frame_type     = frame_kind;
    r.position       = pos;
    r.byte_out       = b;
    r.frame_end      = fin;
    r.status         = st;
    r.target_addr    = hold_tgt;
    r.source_addr    = hold_src;
    r.payload_length = hold_len;

    if (fin) begin
      frame_open  = 1'b0;
      frame_kind  = FT_NONE;
      frame_bytes = '0;
      frame_xor   = '0;
    end else begin
      frame_xor   = frame_xor ^ b;
      frame_bytes = pos + 9'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call, with random idle cycles in front.
  // Driven at the falling edge, accepted at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [7:0] b);
    result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = frame_step(kind, b);
    pending_results.insert(pending_results.size(), r);
    status_tally[r.status]++;
    if (r.status != ST_IGNORED) items_useful++;
    if (kind == KIND_TICK) n_ticks++;
    else n_bytes++;
  endtask

  // rx_byte is don't-care on a tick; keep it random so it toggles anyway.
  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom));
  endtask

  // A byte meant for a frame; with jitter on, a few ticks (never enough to
  // time the frame out) may come first.
  task automatic framed_byte(input logic [7:0] b);
    if (tick_jitter && rx_timeout > 16'd1 && $urandom_range(0, 9) == 0)
      send_ticks($urandom_range(1, rx_timeout > 16'd5 ? 4 : int'(rx_timeout) - 1));
    send_item(KIND_BYTE, b);
  endtask

  // Full message frame with random addresses and payload; the checksum byte
  // is flipped when corrupt is set. With len 0 the last byte is arbitrary.
  task automatic send_message(input logic [7:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] tgt;
    logic [7:0] src;
    logic [7:0] data;
    tgt = 8'($urandom);
    src = 8'($urandom);
    sum = msg_marker ^ tgt ^ src ^ len;
    framed_byte(msg_marker);
    framed_byte(tgt);
    framed_byte(src);
    framed_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      data = 8'($urandom);
      sum  = sum ^ data;
      framed_byte(data);
    end
    framed_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic send_ack;
    framed_byte(ack_marker);
    framed_byte(8'($urandom));
    framed_byte(8'($urandom));
  endtask

  // Stop offering input and wait until every expected result has arrived,
  // then a few more cycles so the pipeline is truly empty.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes (only while the block is drained)
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MSG_MARKER: msg_marker = value[7:0];
      CFG_ACK_MARKER: ack_marker = value[7:0];
      CFG_TIMEOUT:    rx_timeout = value;
      CFG_CHECK_EN:   chk_en     = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] m, input logic [7:0] a,
                               input logic [15:0] tmo, input logic chk);
    cfg_write(CFG_MSG_MARKER, {8'd0, m});
    cfg_write(CFG_ACK_MARKER, {8'd0, a});
    cfg_write(CFG_TIMEOUT,    tmo);
    cfg_write(CFG_CHECK_EN,   {15'd0, chk});
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and a checker against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction (status %0d, byte %0d)",
               out_status, out_byte_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("byte_valid",     want.byte_valid,     out_byte_valid);
        check_field("frame_type",     want.frame_type,     out_frame_type);
        check_field("position",       want.position,       out_position);
        check_field("byte_out",       want.byte_out,       out_byte_out);
        check_field("frame_end",      want.frame_end,      out_frame_end);
        check_field("status",         want.status,         out_status);
        check_field("target_addr",    want.target_addr,    out_target_addr);
        check_field("source_addr",    want.source_addr,    out_source_addr);
        check_field("payload_length", want.payload_length, out_payload_length);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked items: ignored byte, plain tick, good / bad / empty messages,
  // an ack frame right after a message (headers must read zero), and a
  // timeout where an in-frame byte restarts the idle count.
  task automatic test_directed;
    tick_jitter = 1'b0;
    apply_setting(8'hA5, 8'h06, 16'd2, 1'b1);
    send_item(KIND_BYTE, 8'h00);          // no frame open, not a marker
    send_item(KIND_TICK, 8'hFF);          // nothing to discard
    send_message(8'd1, 1'b0);
    send_item(KIND_BYTE, 8'h06);          // ack frame, extremes as body
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_message(8'd0, 1'b0);             // zero length ends at position 4
    send_message(8'd2, 1'b1);             // bad checksum
    send_item(KIND_BYTE, 8'hA5);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'h3C);          // byte clears the idle count
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);          // second idle tick drops the frame
    drain();
  endtask

  // Random mix of mostly well-formed frames with broken frames and noise.
  task automatic run_traffic(input int n);
    int         goal;
    int         pick;
    int         roll;
    logic [7:0] len;
    goal = items_useful + n;
    while (items_useful < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        roll = $urandom_range(0, 199);
        if (roll < 170) len = 8'($urandom_range(0, 8));
        else if (roll < 199) len = 8'($urandom_range(9, 40));
        else len = 8'($urandom_range(100, 255));
        send_message(len, $urandom_range(0, 3) == 0);
      end else if (pick < 67) begin
        send_ack();
      end else if (pick < 77 && rx_timeout <= 16'd40) begin
        // frame start and up to five random bytes, then enough ticks to drop any open frame
        framed_byte($urandom_range(0, 1) ? msg_marker : ack_marker);
        repeat ($urandom_range(0, 5)) framed_byte(8'($urandom));
        send_ticks(int'(rx_timeout) + $urandom_range(0, 2));
      end else if (pick < 87) begin
        send_ticks($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
      end
    end
  endtask

  // Each idle mode runs through four register settings: random distinct
  // markers, the all-zero/all-one extremes with the shortest timeout and
  // checking off, the reverse with the longest timeout, and equal markers.
  task automatic test_traffic_sweep;
    logic [7:0] m;
    tick_jitter = 1'b1;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 15; recv_idle_pct = 49; end
        1:       begin send_idle_pct = 49; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain();
        m = 8'($urandom);
        case (s)
          0: apply_setting(m, m ^ 8'($urandom_range(1, 255)),
                           16'($urandom_range(2, 12)), 1'b1);
          1: apply_setting(8'h00, 8'hFF, 16'd1, 1'b0);
          2: apply_setting(8'hFF, 8'h00, 16'hFFFF, 1'b1);
          default: apply_setting(m, m, 16'($urandom_range(3, 30)),
                                 1'($urandom_range(0, 1)));
        endcase
        run_traffic(TRAFFIC_ITEMS);
      end
    end
    tick_jitter = 1'b0;
    drain();
  endtask

  // Longest legal message: length 255 puts the checksum at position 259.
  task automatic test_longest_frame;
    apply_setting(8'h7E, 8'h7D, 16'd500, 1'b1);
    send_message(8'd255, 1'b0);
    send_message(8'd255, 1'b1);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_traffic_sweep();
    test_longest_frame();

    $display("Sent %0d transactions (%0d bytes, %0d ticks), checked %0d results",
             n_bytes + n_ticks, n_bytes, n_ticks, n_checked);
    $display("Frame outcomes: %0d ok, %0d checksum errors, %0d empty, %0d acks, %0d timeouts",
             status_tally[ST_MSG_OK], status_tally[ST_CHK_ERR], status_tally[ST_EMPTY],
             status_tally[ST_ACK_DONE], status_tally[ST_TIMEOUT]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mlfr_pkg.sv
rtl/mlfr_cfg.sv
rtl/mlfr_core.sv
rtl/marker_length_frame_receiver.sv
bench/tb.sv
